### src/rsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsd_pkg
// Shared types for the rolling standard deviation unit.
// ---------------------------------------------------------------------------
package rsd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int RESULT_W = 24;
    localparam int CFG_W    = 9;
    localparam int LEN_RESET = 20;

    // Request op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [RESULT_W-1:0] std_dev;
        logic                valid_res;
    } t_out;

    // Classified request passed from front to back
    typedef struct packed {
        logic                is_clear;
        logic [SAMPLE_W-1:0] sample;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_UPD,
        ST_MUL,
        ST_DIV,
        ST_SQRT
    } t_bstate;

endpackage
`default_nettype wire

### src/rsd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsd_front
// Accepts requests, decodes the op and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module rsd_front import rsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_q_valid,
    output t_req      o_q_data,
    input  wire logic i_q_pop
);

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_req       w_req;

    // classify incoming request
    always_comb begin
        w_req.is_clear = (i_in_data.op == OP_CLEAR);
        w_req.sample   = i_in_data.sample;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rp];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_req;
    end

endmodule
`default_nettype wire

### src/rsd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsd_back
// Window store, running sums, and the serial multiply, divide and root.
// ---------------------------------------------------------------------------
module rsd_back import rsd_pkg::*; #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_q_valid,
    input  wire t_req             i_q_data,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out                  o_out_data
);

    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int IW    = $clog2(MAX_WINDOW);
    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + IW + 1;
    localparam int SQ_W  = 2 * SB + IW - 1;
    localparam int D_W   = SQ_W + NW;
    localparam int DVW   = 2 * NW;
    localparam int RS    = (D_W + 1) / 2;
    localparam int CW    = $clog2(D_W + 2);
    localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

    t_bstate r_state, n_state;

    logic [NW-1:0]          r_len, r_fill;
    logic [IW-1:0]          r_widx, r_idx;
    logic                   r_full;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]        r_sq;
    logic signed [SB-1:0]   r_mem [MAX_WINDOW];
    logic signed [SB-1:0]   r_rd, r_x, r_oldv;
    logic [2*SB-1:0]        r_px, r_po;

    logic [D_W-1:0]         r_acc_a, r_acc_b, r_mc_a, r_mc_b;
    logic [NW-1:0]          r_mp_a;
    logic [SUM_W-1:0]       r_mp_b;
    logic [CW-1:0]          r_cnt;
    logic [D_W-1:0]         r_dq;
    logic [DVW:0]           r_rem;
    logic [DVW-1:0]         r_dv;
    logic [2*RS-1:0]        r_rad;
    logic [RS-1:0]          r_root;
    logic [RS+1:0]          r_srem;

    logic                   r_out_valid;
    t_out                   r_out;

    logic                   w_out_free, w_pop;
    logic [NW-1:0]          w_cfg_len;
    logic [IW-1:0]          w_idx;
    logic signed [SB-1:0]   w_old;
    logic signed [SUM_W-1:0] w_sum_nx;
    logic [SQ_W-1:0]        w_sq_nx;
    logic [NW-1:0]          w_fill_nx;
    logic                   w_full_nx;
    logic [SUM_W-1:0]       w_mag;
    logic [D_W-1:0]         w_diff;
    logic [DVW:0]           w_rem_sh;
    logic                   w_div_ge;
    logic [RS+1:0]          w_srem_sh, w_trial;
    logic                   w_sq_ge;
    logic                   w_last;

    // effective window length from a config write
    always_comb begin
        if (i_cfg_wdata == '0) w_cfg_len = NW'(1);
        else if (32'(i_cfg_wdata) > MAX_WINDOW) w_cfg_len = NW'(MAX_WINDOW);
        else w_cfg_len = NW'(i_cfg_wdata);
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_pop      = (r_state == ST_IDLE) && i_q_valid && w_out_free;
    assign o_q_pop    = w_pop;
    assign w_last     = (r_cnt == CW'(1));

    // slot to replace; entries not written since a clear read as zero
    assign w_idx = (NW'(r_widx) >= r_len) ? '0 : r_widx;
    assign w_old = r_full ? r_rd : '0;

    // window update
    always_comb begin
        w_sum_nx  = r_sum + SUM_W'(r_x) - SUM_W'(r_oldv);
        w_sq_nx   = r_sq + SQ_W'(r_px) - SQ_W'(r_po);
        w_fill_nx = r_full ? r_fill : r_fill + NW'(1);
        w_full_nx = r_full || (w_fill_nx >= r_len);
        w_mag     = w_sum_nx[SUM_W-1] ? SUM_W'(-w_sum_nx) : SUM_W'(w_sum_nx);
    end

    // divide and root steps
    always_comb begin
        w_diff    = (r_acc_a >= r_acc_b) ? r_acc_a - r_acc_b : '0;
        w_rem_sh  = {r_rem[DVW-1:0], r_dq[D_W-1]};
        w_div_ge  = (w_rem_sh >= {1'b0, r_dv});
        w_srem_sh = {r_srem[RS-1:0], r_rad[2*RS-1 -: 2]};
        w_trial   = {r_root, 2'b01};
        w_sq_ge   = (w_srem_sh >= w_trial);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_pop && !i_q_data.is_clear) n_state = ST_READ;
            ST_READ: n_state = ST_SQ;
            ST_SQ:   n_state = ST_UPD;
            ST_UPD:  n_state = w_full_nx ? ST_MUL : ST_IDLE;
            ST_MUL:  if (w_last) n_state = ST_DIV;
            ST_DIV:  if (w_last) n_state = ST_SQRT;
            ST_SQRT: if (w_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // window state, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= NW'(LEN_RST);
            r_widx      <= '0;
            r_fill      <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_len  <= w_cfg_len;
                r_widx <= '0;
                r_fill <= '0;
                r_full <= 1'b0;
                r_sum  <= '0;
                r_sq   <= '0;
            end else begin
                if (w_pop && i_q_data.is_clear) begin
                    r_widx      <= '0;
                    r_fill      <= '0;
                    r_full      <= 1'b0;
                    r_sum       <= '0;
                    r_sq        <= '0;
                    r_out_valid <= 1'b1;
                    r_out       <= '0;
                end
                if (r_state == ST_UPD) begin
                    r_sum  <= w_sum_nx;
                    r_sq   <= w_sq_nx;
                    r_fill <= w_fill_nx;
                    r_full <= w_full_nx;
                    r_widx <= (NW'(r_idx) + NW'(1) >= r_len) ? '0 : r_idx + IW'(1);
                    if (!w_full_nx) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '0;
                    end
                end
                if (r_state == ST_SQRT && w_last) begin
                    r_out_valid       <= 1'b1;
                    r_out.std_dev     <= RESULT_W'(w_sq_ge ? {r_root[RS-2:0], 1'b1}
                                                           : {r_root[RS-2:0], 1'b0});
                    r_out.valid_res   <= 1'b1;
                end
            end
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (w_pop) r_rd <= r_mem[w_idx];
        if (r_state == ST_UPD) r_mem[r_idx] <= r_x;
    end

    // datapath: squares, serial multiply, restoring divide, digit root
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x   <= SB'(i_q_data.sample);
                r_idx <= w_idx;
            end
            ST_READ: r_px <= (2*SB)'(r_x * r_x);
            ST_SQ: begin
                r_oldv <= w_old;
                r_po   <= (2*SB)'(w_old * w_old);
            end
            ST_UPD: begin
                r_acc_a <= '0;
                r_acc_b <= '0;
                r_mc_a  <= D_W'(w_sq_nx);
                r_mp_a  <= r_len;
                r_mc_b  <= D_W'(w_mag);
                r_mp_b  <= w_mag;
                r_cnt   <= CW'(SUM_W);
            end
            ST_MUL: begin
                if (r_mp_a[0]) r_acc_a <= r_acc_a + r_mc_a;
                if (r_mp_b[0]) r_acc_b <= r_acc_b + r_mc_b;
                r_mc_a <= r_mc_a << 1;
                r_mc_b <= r_mc_b << 1;
                r_mp_a <= r_mp_a >> 1;
                r_mp_b <= r_mp_b >> 1;
                r_cnt  <= r_cnt - CW'(1);
                if (w_last) begin
                    r_cnt <= CW'(D_W + 1);
                    r_rem <= '0;
                    r_dv  <= DVW'(r_len * r_len);
                end
            end
            ST_DIV: begin
                if (r_cnt == CW'(D_W + 1)) begin
                    // first cycle: take the difference of the two products
                    r_dq  <= w_diff;
                    r_cnt <= CW'(D_W);
                end else begin
                    r_rem <= w_div_ge ? w_rem_sh - {1'b0, r_dv} : w_rem_sh;
                    r_dq  <= {r_dq[D_W-2:0], w_div_ge};
                    r_cnt <= r_cnt - CW'(1);
                end
                if (w_last) begin
                    r_rad  <= (2*RS)'({r_dq[D_W-2:0], w_div_ge});
                    r_root <= '0;
                    r_srem <= '0;
                    r_cnt  <= CW'(RS);
                end
            end
            ST_SQRT: begin
                r_srem <= w_sq_ge ? w_srem_sh - w_trial : w_srem_sh;
                r_root <= {r_root[RS-2:0], w_sq_ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - CW'(1);
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len) else $error("fill count beyond window length");
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_fill == r_len) else $error("full flag without full window");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == ST_IDLE) else $error("pop outside idle");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT && w_last) |-> !r_out_valid)
        else $error("result would overwrite held output");

endmodule
`default_nettype wire

### src/rolling_standard_deviation_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rolling_standard_deviation_unit
// Moving population standard deviation over a window of Q12.12 samples.
// ---------------------------------------------------------------------------
// A sample over a full window passes through the bit-serial multiply, the restoring
//   divider and the digit-by-digit root before its result; warm-up samples and clears
//   give a zero result without them.
// The back end takes one request at a time; a two-entry queue keeps accepting while
//   it works, until it fills. Reset is synchronous and active low, sets the window
//   length to 20 and empties the window.
module rolling_standard_deviation_unit import rsd_pkg::*; #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out                  o_out_data
);

    logic w_q_valid, w_q_pop;
    t_req w_q_data;

    rsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .o_q_data   (w_q_data),
        .i_q_pop    (w_q_pop)
    );

    rsd_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Checks the rolling standard deviation unit against an exact integer model
// of the window, running sums and floor square root, under random idling.
// ---------------------------------------------------------------------------

class stddev_scoreboard;
    int unsigned      eff_len;
    logic signed [23:0] window_mem [256];
    int unsigned      wr_ptr;
    int unsigned      fill_cnt;
    bit               full;
    longint signed    sum1;
    logic [63:0]      sum2;
    rsd_pkg::t_out    pending_q [$];
    int               errors;

    function new();
        errors = 0;
        set_length(9'(rsd_pkg::LEN_RESET));
    endfunction

    function void wipe();
        foreach (window_mem[i]) window_mem[i] = '0;
        wr_ptr = 0;
        fill_cnt = 0;
        full = 0;
        sum1 = 0;
        sum2 = '0;
    endfunction

    function void set_length(logic [8:0] val);
        if (val == 0) eff_len = 1;
        else if (val > 256) eff_len = 256;
        else eff_len = val;
        wipe();
    endfunction

    static function logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void note_request(rsd_pkg::t_in req);
        rsd_pkg::t_out exp;
        longint signed x, old;
        int unsigned idx;
        logic [127:0] a, bb, d;
        logic [63:0] mag;
        exp = '0;
        if (req.op == rsd_pkg::OP_CLEAR) begin
            wipe();
        end else begin
            x = req.sample;
            idx = (wr_ptr >= eff_len) ? 0 : wr_ptr;
            old = window_mem[idx];
            window_mem[idx] = req.sample;
            wr_ptr = (idx + 1 >= eff_len) ? 0 : idx + 1;
            sum1 += x - old;
            sum2 = sum2 + 64'(x * x) - 64'(old * old);
            if (!full) begin
                fill_cnt++;
                if (fill_cnt >= eff_len) full = 1;
            end
            if (full) begin
                mag = (sum1 < 0) ? 64'(-sum1) : 64'(sum1);
                a = 128'(eff_len) * 128'(sum2);
                bb = 128'(mag) * 128'(mag);
                if (a >= bb) begin
                    d = (a - bb) / 128'(eff_len * eff_len);
                    exp.std_dev = 24'(root_floor(d[63:0]));
                end
                exp.valid_res = 1'b1;
            end
        end
        pending_q.push_back(exp);
    endfunction

    function void check_result(rsd_pkg::t_out got);
        rsd_pkg::t_out exp;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result std_dev=%0d valid=%0b",
                     $time, got.std_dev, got.valid_res);
            errors++;
            return;
        end
        exp = pending_q.pop_front();
        if (got.std_dev !== exp.std_dev) begin
            $display("%0t: std_dev expected %0d actual %0d",
                     $time, exp.std_dev, got.std_dev);
            errors++;
        end
        if (got.valid_res !== exp.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b",
                     $time, exp.valid_res, got.valid_res);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import rsd_pkg::*;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       cfg_we = 0;
    logic [8:0] cfg_wdata = '0;
    logic       in_valid = 0;
    logic       in_stall;
    t_in        in_data = '0;
    logic       out_valid;
    logic       out_stall = 0;
    t_out       out_data;

    stddev_scoreboard sb = new();

    rolling_standard_deviation_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #4 clk = ~clk;

    // Send one request, with a random gap first; valid stays up for back to back
    task automatic send_req(t_in req, bit idle_ok = 1);
        int gap;
        gap = idle_ok ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        sb.note_request(req);
    endtask

    task automatic send_sample(logic [23:0] s);
        t_in r;
        r.op = OP_SAMPLE;
        r.sample = s;
        send_req(r);
    endtask

    task automatic send_clear();
        t_in r;
        r.op = OP_CLEAR;
        r.sample = 24'($urandom);
        send_req(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Length change only while idle
    task automatic write_length(logic [8:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_length(val);
    endtask

    function automatic logic [23:0] rand_sample(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 8191)) - 4096);
            2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($urandom_range(0, 255) << 12);
        endcase
    endfunction

    // Result side: random stall, check on accept
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            out_stall <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 8) != 0) : 1'b0;
        end
    end

    initial begin
        int lens [14] = '{2, 256, 3, 5, 17, 300, 1, 64, 8, 2, 33, 256, 4, 12};
        int cnt;
        int mode;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default length, extremes, clear, warm-up
        for (int i = 0; i < 19; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000);
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_clear();
        write_length(9'd1);
        send_sample(24'h800000);
        send_sample(24'h123456);
        write_length(9'd0);
        send_sample(24'h7FFFFF);
        write_length(9'd511);
        send_sample(24'hFFFFFF);

        // Random phases over several lengths
        cnt = 0;
        foreach (lens[k]) begin
            write_length(9'(lens[k]));
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 140 && cnt < 1950; i++, cnt++) begin
                if ($urandom_range(0, 49) == 0) send_clear();
                else send_sample(rand_sample($urandom_range(0, 4) == 0
                                             ? $urandom_range(0, 3) : mode));
                if (i == 70) drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
